// ----- rtl/core/ipff_pkg.sv -----
// shared types, constants and helpers for the ipv4 five-tuple frame filter
// no dependencies; imported by every module of the filter except ipff_checker
package ipff_pkg;

   // frame length saturation point
   localparam logic [15:0] MAX_FRAME_BYTES = 16'd65535;

   // protocol constants
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  L4_PROTO_TCP   = 8'd6;
   localparam logic [7:0]  L4_PROTO_UDP   = 8'd17;

   // header layout
   localparam logic [15:0] ETH_HDR_BYTES  = 16'd14;
   localparam logic [15:0] IP_MIN_BYTES   = 16'd34;
   localparam logic [3:0]  IHL_MIN        = 4'd5;
   localparam logic [7:0]  TCP_HDR_BYTES  = 8'd20;
   localparam logic [7:0]  UDP_HDR_BYTES  = 8'd8;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MATCH_ENABLES = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOURCE_MAC    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEST_MAC      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOURCE_IPV4   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEST_IPV4     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOURCE_PORT   = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEST_PORT     = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PROTOCOL      = 3'd7;

   // match enable bits
   localparam int unsigned EN_SRC_MAC = 0;
   localparam int unsigned EN_DST_MAC = 1;
   localparam int unsigned EN_SRC_IP  = 2;
   localparam int unsigned EN_DST_IP  = 3;

   // drop reasons
   typedef enum logic [3:0] {
      REASON_PASS      = 4'd0,
      REASON_NOT_IPV4  = 4'd1,
      REASON_MAC       = 4'd2,
      REASON_IP        = 4'd3,
      REASON_PROTOCOL  = 4'd4,
      REASON_NOT_L4    = 4'd5,
      REASON_PORT      = 4'd6,
      REASON_TRUNCATED = 4'd7,
      REASON_BAD_IHL   = 4'd8
   } reason_type;

   // configuration register file contents
   typedef struct packed {
      logic [3:0]  match_enables;
      logic [47:0] source_mac;
      logic [47:0] dest_mac;
      logic [31:0] source_ipv4;
      logic [31:0] dest_ipv4;
      logic [15:0] source_port_want;
      logic [15:0] dest_port_want;
      logic [7:0]  protocol_want;
   } cfg_type;

   // one verdict beat
   typedef struct packed {
      logic        accepted;
      reason_type  drop_reason;
      logic [7:0]  ip_protocol;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [7:0]  payload_offset;
      logic [15:0] frame_length;
   } verdict_type;

   // byte of a mac address, index 0 is the first wire byte
   function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0: b = mac[47:40];
         3'd1: b = mac[39:32];
         3'd2: b = mac[31:24];
         3'd3: b = mac[23:16];
         3'd4: b = mac[15:8];
         3'd5: b = mac[7:0];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // byte of an ipv4 address, index 0 is the first wire byte
   function automatic logic [7:0] ip_byte(input logic [31:0] ip, input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0: b = ip[31:24];
         2'd1: b = ip[23:16];
         2'd2: b = ip[15:8];
         2'd3: b = ip[7:0];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// ----- rtl/core/ipff_csr.sv -----
// configuration register file of the frame filter
// depends on ipff_pkg for the register indexes and cfg_type
module ipff_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wen,
   input  logic [ipff_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [47:0]                          csr_wdata,
   output ipff_pkg::cfg_type                    cfg
);
   import ipff_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // decode one register write, upper data bits dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_MATCH_ENABLES: cfg_in.match_enables    = csr_wdata[3:0];
            CSR_SOURCE_MAC:    cfg_in.source_mac       = csr_wdata;
            CSR_DEST_MAC:      cfg_in.dest_mac         = csr_wdata;
            CSR_SOURCE_IPV4:   cfg_in.source_ipv4      = csr_wdata[31:0];
            CSR_DEST_IPV4:     cfg_in.dest_ipv4        = csr_wdata[31:0];
            CSR_SOURCE_PORT:   cfg_in.source_port_want = csr_wdata[15:0];
            CSR_DEST_PORT:     cfg_in.dest_port_want   = csr_wdata[15:0];
            CSR_PROTOCOL:      cfg_in.protocol_want    = csr_wdata[7:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/core/ipff_parse.sv -----
// input register, per-frame header state and verdict logic of the frame filter
// depends on ipff_pkg for constants, cfg_type, verdict_type and byte helpers
module ipff_parse (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_byte_value,
   input  logic                    req_frame_end,
   input  ipff_pkg::cfg_type       cfg,
   input  logic                    out_ready,
   output logic                    out_push,
   output ipff_pkg::verdict_type   out_verdict
);
   import ipff_pkg::*;

   // input register
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       end_ff;

   // frame state
   logic [15:0] offset_ff, offset_in;
   logic [15:0] ethertype_ff, ethertype_in;
   logic [3:0]  ihl_ff, ihl_in;
   logic [7:0]  proto_ff, proto_in;
   logic [15:0] sport_ff, sport_in;
   logic [15:0] dport_ff, dport_in;
   logic [3:0]  tcpoff_ff, tcpoff_in;
   logic [3:0]  flags_ff, flags_in;

   logic        req_accept;
   logic        fire;
   logic [15:0] pos;
   logic [7:0]  l4_cur;
   logic [7:0]  l4_new;
   logic [15:0] len;
   reason_type  reason;
   logic [7:0]  pay;

   // a buffered byte moves on unless it ends a frame and the result slot is held
   assign fire       = valid_ff && (!end_ff || out_ready);
   assign req_stall  = valid_ff && !fire;
   assign req_accept = req_valid && !req_stall;
   assign valid_in   = req_accept ? 1'b1 : (fire ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         byte_ff <= req_byte_value;
         end_ff  <= req_frame_end;
      end
   end

   assign pos    = offset_ff;
   assign l4_cur = 8'd14 + {2'b00, ihl_ff, 2'b00};

   // header field capture and address compares for the buffered byte
   always_comb begin
      ethertype_in = ethertype_ff;
      ihl_in       = ihl_ff;
      proto_in     = proto_ff;
      sport_in     = sport_ff;
      dport_in     = dport_ff;
      tcpoff_in    = tcpoff_ff;
      flags_in     = flags_ff;
      if (pos < 16'd6) begin
         if (mac_byte(cfg.dest_mac, pos[2:0]) != byte_ff) begin
            flags_in[EN_DST_MAC] = 1'b0;
         end
      end else if (pos < 16'd12) begin
         if (mac_byte(cfg.source_mac, 3'(pos[3:0] - 4'd6)) != byte_ff) begin
            flags_in[EN_SRC_MAC] = 1'b0;
         end
      end else if (pos < ETH_HDR_BYTES) begin
         ethertype_in = {ethertype_ff[7:0], byte_ff};
      end else if (pos == ETH_HDR_BYTES) begin
         ihl_in = byte_ff[3:0];
      end else begin
         if (pos == 16'd23) begin
            proto_in = byte_ff;
         end
         if (pos >= 16'd26 && pos < 16'd30) begin
            if (ip_byte(cfg.source_ipv4, 2'(pos[4:0] - 5'd26)) != byte_ff) begin
               flags_in[EN_SRC_IP] = 1'b0;
            end
         end
         if (pos >= 16'd30 && pos < IP_MIN_BYTES) begin
            if (ip_byte(cfg.dest_ipv4, 2'(pos[5:0] - 6'd30)) != byte_ff) begin
               flags_in[EN_DST_IP] = 1'b0;
            end
         end
         // transport header fields, located by the ip header length
         if (ihl_ff >= IHL_MIN) begin
            if (pos == {8'h00, l4_cur}) begin
               sport_in = {byte_ff, 8'h00};
            end else if (pos == {8'h00, l4_cur + 8'd1}) begin
               sport_in = sport_ff | {8'h00, byte_ff};
            end else if (pos == {8'h00, l4_cur + 8'd2}) begin
               dport_in = {byte_ff, 8'h00};
            end else if (pos == {8'h00, l4_cur + 8'd3}) begin
               dport_in = dport_ff | {8'h00, byte_ff};
            end else if (pos == {8'h00, l4_cur + 8'd12}) begin
               tcpoff_in = byte_ff[7:4];
            end
         end
      end
   end

   // saturating byte count
   assign offset_in = (offset_ff == 16'hFFFF) ? offset_ff : offset_ff + 16'd1;
   assign len       = offset_in;
   assign l4_new    = 8'd14 + {2'b00, ihl_in, 2'b00};

   // verdict, first failing check wins
   always_comb begin
      if (len < ETH_HDR_BYTES) begin
         reason = REASON_TRUNCATED;
      end else if (ethertype_in != ETHERTYPE_IPV4) begin
         reason = REASON_NOT_IPV4;
      end else if (cfg.match_enables[EN_SRC_MAC] && !flags_in[EN_SRC_MAC]) begin
         reason = REASON_MAC;
      end else if (cfg.match_enables[EN_DST_MAC] && !flags_in[EN_DST_MAC]) begin
         reason = REASON_MAC;
      end else if (len < IP_MIN_BYTES) begin
         reason = REASON_TRUNCATED;
      end else if (ihl_in < IHL_MIN) begin
         reason = REASON_BAD_IHL;
      end else if (cfg.match_enables[EN_SRC_IP] && !flags_in[EN_SRC_IP]) begin
         reason = REASON_IP;
      end else if (cfg.match_enables[EN_DST_IP] && !flags_in[EN_DST_IP]) begin
         reason = REASON_IP;
      end else if (cfg.protocol_want != 8'h00 && cfg.protocol_want != proto_in) begin
         reason = REASON_PROTOCOL;
      end else if (proto_in != L4_PROTO_TCP && proto_in != L4_PROTO_UDP) begin
         reason = REASON_NOT_L4;
      end else if (proto_in == L4_PROTO_TCP && len < {8'h00, l4_new + TCP_HDR_BYTES}) begin
         reason = REASON_TRUNCATED;
      end else if (proto_in == L4_PROTO_UDP && len < {8'h00, l4_new + UDP_HDR_BYTES}) begin
         reason = REASON_TRUNCATED;
      end else if (cfg.source_port_want != 16'h0000 && cfg.source_port_want != sport_in) begin
         reason = REASON_PORT;
      end else if (cfg.dest_port_want != 16'h0000 && cfg.dest_port_want != dport_in) begin
         reason = REASON_PORT;
      end else begin
         reason = REASON_PASS;
      end
   end

   // payload offset from the ip header length and the tcp or udp header length
   always_comb begin
      pay = 8'h00;
      if (ihl_in >= IHL_MIN) begin
         if (proto_in == L4_PROTO_TCP) begin
            pay = l4_new + {2'b00, tcpoff_in, 2'b00};
         end else if (proto_in == L4_PROTO_UDP) begin
            pay = l4_new + UDP_HDR_BYTES;
         end
      end
   end

   // result beat
   always_comb begin
      out_verdict.accepted       = (reason == REASON_PASS);
      out_verdict.drop_reason    = reason;
      out_verdict.ip_protocol    = proto_in;
      out_verdict.src_port       = sport_in;
      out_verdict.dst_port       = dport_in;
      out_verdict.payload_offset = pay;
      out_verdict.frame_length   = (len > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : len;
   end

   assign out_push = fire && end_ff;

   // frame state update, restored to its start values after the last byte
   always_ff @(posedge clock) begin
      if (reset || (fire && end_ff)) begin
         offset_ff    <= '0;
         ethertype_ff <= '0;
         ihl_ff       <= '0;
         proto_ff     <= '0;
         sport_ff     <= '0;
         dport_ff     <= '0;
         tcpoff_ff    <= '0;
         flags_ff     <= '1;
      end else if (fire) begin
         offset_ff    <= offset_in;
         ethertype_ff <= ethertype_in;
         ihl_ff       <= ihl_in;
         proto_ff     <= proto_in;
         sport_ff     <= sport_in;
         dport_ff     <= dport_in;
         tcpoff_ff    <= tcpoff_in;
         flags_ff     <= flags_in;
      end
   end

endmodule

// ----- rtl/core/ipff_out.sv -----
// result register of the frame filter, holds one verdict beat under stall
// depends on ipff_pkg for verdict_type
module ipff_out (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  ipff_pkg::verdict_type   push_verdict,
   output logic                    ready,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output ipff_pkg::verdict_type   rsp_verdict
);
   import ipff_pkg::*;

   logic        valid_ff, valid_in;
   verdict_type verdict_ff;

   // slot is free when empty or being taken this cycle
   assign ready    = !valid_ff || !rsp_stall;
   assign valid_in = (push && ready) ? 1'b1 : (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && ready) begin
         verdict_ff <= push_verdict;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_verdict = verdict_ff;

endmodule

// ----- rtl/core/ipv4_five_tuple_frame_filter_core.sv -----
// Ethernet/IPv4 TCP-UDP header filter. Takes one frame byte per cycle on the req_
// channel while req_stall is low, starting at the destination MAC, and gives one
// verdict beat on the rsp_ channel for each byte marked frame_end. A verdict passes
// through the input register, then the result register. The input side stalls only
// while a finished verdict sits in the result register and the next frame end is
// waiting behind it. Registers on the csr_ port are held in ipff_csr; the user must
// see that they are written only while no frame is in flight, which the block does
// not enforce. Depends on ipff_pkg, ipff_csr, ipff_parse and ipff_out.
module ipv4_five_tuple_frame_filter_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_byte_value,
   input  logic                                 req_frame_end,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_accepted,
   output logic [3:0]                           rsp_drop_reason,
   output logic [7:0]                           rsp_ip_protocol,
   output logic [15:0]                          rsp_src_port,
   output logic [15:0]                          rsp_dst_port,
   output logic [7:0]                           rsp_payload_offset,
   output logic [15:0]                          rsp_frame_length,
   input  logic                                 csr_wen,
   input  logic [ipff_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [47:0]                          csr_wdata
);
   import ipff_pkg::*;

   cfg_type     cfg;
   logic        out_ready;
   logic        out_push;
   verdict_type push_verdict;
   verdict_type rsp_verdict;

   // configuration registers
   ipff_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // header parsing and verdict
   ipff_parse u_parse (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_byte_value (req_byte_value),
      .req_frame_end  (req_frame_end),
      .cfg            (cfg),
      .out_ready      (out_ready),
      .out_push       (out_push),
      .out_verdict    (push_verdict)
   );

   // result register
   ipff_out u_out (
      .clock        (clock),
      .reset        (reset),
      .push         (out_push),
      .push_verdict (push_verdict),
      .ready        (out_ready),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_verdict  (rsp_verdict)
   );

   // result fields
   assign rsp_accepted       = rsp_verdict.accepted;
   assign rsp_drop_reason    = rsp_verdict.drop_reason;
   assign rsp_ip_protocol    = rsp_verdict.ip_protocol;
   assign rsp_src_port       = rsp_verdict.src_port;
   assign rsp_dst_port       = rsp_verdict.dst_port;
   assign rsp_payload_offset = rsp_verdict.payload_offset;
   assign rsp_frame_length   = rsp_verdict.frame_length;

endmodule

// ----- rtl/core/ipff_checker.sv -----
// port-level checks of the frame filter top level, attached by bind
// depends only on the top level's ports
module ipff_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_stall,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_accepted,
   input  logic [3:0]  rsp_drop_reason,
   input  logic [7:0]  rsp_payload_offset,
   input  logic [15:0] rsp_frame_length
);

   // a held verdict beat keeps its fields
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_drop_reason)
         && $stable(rsp_frame_length) && $stable(rsp_payload_offset))
      else $error("verdict beat changed under stall");

   // accepted flag agrees with the pass reason
   a_accept_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_accepted == (rsp_drop_reason == 4'd0)))
      else $error("accepted flag disagrees with drop reason");

   // input side only backs up behind a held verdict
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with free result slot");

   // no verdict right out of reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("verdict beat present after reset");

endmodule

bind ipv4_five_tuple_frame_filter_core ipff_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_accepted       (rsp_accepted),
   .rsp_drop_reason    (rsp_drop_reason),
   .rsp_payload_offset (rsp_payload_offset),
   .rsp_frame_length   (rsp_frame_length)
);

// ----- tb/sv/tb.sv -----
// self-checking testbench for ipv4_five_tuple_frame_filter_core: byte-stream frames in,
// one verdict beat per frame out, compared field by field against an in-bench filter model
// depends on ipff_pkg and the core rtl only
module tb;
   import ipff_pkg::*;

   localparam int unsigned TAIL_ITEMS    = 200;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned PHASES        = 6;

   typedef enum logic [1:0] {ITEM_BYTE, ITEM_CSR, ITEM_PAUSE} item_kind_type;

   typedef struct {
      item_kind_type             kind;
      logic [7:0]                data;
      logic                      last;
      logic [CSR_INDEX_BITS-1:0] idx;
      logic [47:0]               wdata;
   } bus_item_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [7:0]                req_byte_value = '0;
   logic                      req_frame_end = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_accepted;
   logic [3:0]                rsp_drop_reason;
   logic [7:0]                rsp_ip_protocol;
   logic [15:0]               rsp_src_port;
   logic [15:0]               rsp_dst_port;
   logic [7:0]                rsp_payload_offset;
   logic [15:0]               rsp_frame_length;
   logic                      csr_wen = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [47:0]               csr_wdata = '0;

   // stimulus plan and expected verdicts
   bus_item_type item_q[$];
   verdict_type  verdict_q[$];
   cfg_type      plan_cfg = '0;
   int unsigned  planned_bytes = 0;

   // filter model state
   cfg_type     filt_cfg = '0;
   int unsigned frm_pos = 0;
   logic [15:0] frm_ethertype = '0;
   logic [3:0]  frm_ihl = '0;
   logic [7:0]  frm_proto = '0;
   logic [15:0] frm_sport = '0;
   logic [15:0] frm_dport = '0;
   logic [3:0]  frm_doff = '0;
   logic [3:0]  frm_match = 4'hF;

   // run bookkeeping
   int unsigned cycle_count = 0;
   int unsigned cycle_limit = 0;
   int unsigned fail_count = 0;
   int unsigned quiet_cycles = 0;
   int unsigned send_left = 0;
   int unsigned stall_left = 0;
   int unsigned send_mode = 1;
   int unsigned stall_mode = 1;
   logic        beat_taken = 1'b0;

   ipv4_five_tuple_frame_filter_core u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_byte_value     (req_byte_value),
      .req_frame_end      (req_frame_end),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_accepted       (rsp_accepted),
      .rsp_drop_reason    (rsp_drop_reason),
      .rsp_ip_protocol    (rsp_ip_protocol),
      .rsp_src_port       (rsp_src_port),
      .rsp_dst_port       (rsp_dst_port),
      .rsp_payload_offset (rsp_payload_offset),
      .rsp_frame_length   (rsp_frame_length),
      .csr_wen            (csr_wen),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // register write effect, shared by the model and the frame planner
   function automatic cfg_type cfg_write(input cfg_type c, input logic [CSR_INDEX_BITS-1:0] idx,
                                         input logic [47:0] d);
      cfg_type n;
      n = c;
      case (idx)
         CSR_MATCH_ENABLES: n.match_enables    = d[3:0];
         CSR_SOURCE_MAC:    n.source_mac       = d;
         CSR_DEST_MAC:      n.dest_mac         = d;
         CSR_SOURCE_IPV4:   n.source_ipv4      = d[31:0];
         CSR_DEST_IPV4:     n.dest_ipv4        = d[31:0];
         CSR_SOURCE_PORT:   n.source_port_want = d[15:0];
         CSR_DEST_PORT:     n.dest_port_want   = d[15:0];
         CSR_PROTOCOL:      n.protocol_want    = d[7:0];
         default:           n = c;
      endcase
      return n;
   endfunction

   // first failing check of the finished frame
   function automatic reason_type frame_verdict(input int unsigned len);
      int unsigned l4;
      l4 = ETH_HDR_BYTES + 4 * frm_ihl;
      if (len < ETH_HDR_BYTES) return REASON_TRUNCATED;
      if (frm_ethertype != ETHERTYPE_IPV4) return REASON_NOT_IPV4;
      if (filt_cfg.match_enables[EN_SRC_MAC] && !frm_match[EN_SRC_MAC]) return REASON_MAC;
      if (filt_cfg.match_enables[EN_DST_MAC] && !frm_match[EN_DST_MAC]) return REASON_MAC;
      if (len < IP_MIN_BYTES) return REASON_TRUNCATED;
      if (frm_ihl < IHL_MIN) return REASON_BAD_IHL;
      if (filt_cfg.match_enables[EN_SRC_IP] && !frm_match[EN_SRC_IP]) return REASON_IP;
      if (filt_cfg.match_enables[EN_DST_IP] && !frm_match[EN_DST_IP]) return REASON_IP;
      if (filt_cfg.protocol_want != 0 && filt_cfg.protocol_want != frm_proto)
         return REASON_PROTOCOL;
      if (frm_proto == L4_PROTO_TCP) begin
         if (len < l4 + TCP_HDR_BYTES) return REASON_TRUNCATED;
      end else if (frm_proto == L4_PROTO_UDP) begin
         if (len < l4 + UDP_HDR_BYTES) return REASON_TRUNCATED;
      end else begin
         return REASON_NOT_L4;
      end
      if (filt_cfg.source_port_want != 0 && filt_cfg.source_port_want != frm_sport)
         return REASON_PORT;
      if (filt_cfg.dest_port_want != 0 && filt_cfg.dest_port_want != frm_dport)
         return REASON_PORT;
      return REASON_PASS;
   endfunction

   // advance the filter model by one accepted byte, queue a verdict on frame end
   task automatic filter_byte(input logic [7:0] b, input logic last);
      int unsigned pos;
      int unsigned l4;
      int unsigned len;
      int unsigned pay;
      verdict_type v;
      pos = frm_pos;
      if (pos < 6) begin
         if (b != filt_cfg.dest_mac[8 * (5 - pos) +: 8]) frm_match[EN_DST_MAC] = 1'b0;
      end else if (pos < 12) begin
         if (b != filt_cfg.source_mac[8 * (11 - pos) +: 8]) frm_match[EN_SRC_MAC] = 1'b0;
      end else if (pos < 14) begin
         frm_ethertype = {frm_ethertype[7:0], b};
      end else if (pos == 14) begin
         frm_ihl = b[3:0];
      end else begin
         if (pos == 23) frm_proto = b;
         if (pos >= 26 && pos < 30) begin
            if (b != filt_cfg.source_ipv4[8 * (29 - pos) +: 8]) frm_match[EN_SRC_IP] = 1'b0;
         end
         if (pos >= 30 && pos < 34) begin
            if (b != filt_cfg.dest_ipv4[8 * (33 - pos) +: 8]) frm_match[EN_DST_IP] = 1'b0;
         end
         // transport fields follow the variable ip header
         if (frm_ihl >= IHL_MIN) begin
            l4 = ETH_HDR_BYTES + 4 * frm_ihl;
            if (pos == l4) frm_sport = {b, 8'h00};
            else if (pos == l4 + 1) frm_sport = frm_sport | b;
            else if (pos == l4 + 2) frm_dport = {b, 8'h00};
            else if (pos == l4 + 3) frm_dport = frm_dport | b;
            else if (pos == l4 + 12) frm_doff = b[7:4];
         end
      end
      if (frm_pos < 65535) frm_pos++;
      if (last) begin
         len = frm_pos;
         pay = 0;
         if (frm_ihl >= IHL_MIN) begin
            l4 = ETH_HDR_BYTES + 4 * frm_ihl;
            if (frm_proto == L4_PROTO_TCP) pay = l4 + 4 * frm_doff;
            else if (frm_proto == L4_PROTO_UDP) pay = l4 + UDP_HDR_BYTES;
         end
         v.drop_reason    = frame_verdict(len);
         v.accepted       = (v.drop_reason == REASON_PASS);
         v.ip_protocol    = frm_proto;
         v.src_port       = frm_sport;
         v.dst_port       = frm_dport;
         v.payload_offset = pay[7:0];
         v.frame_length   = (len > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : len[15:0];
         verdict_q.push_back(v);
         // back to the idle frame state
         frm_pos       = 0;
         frm_ethertype = '0;
         frm_ihl       = '0;
         frm_proto     = '0;
         frm_sport     = '0;
         frm_dport     = '0;
         frm_doff      = '0;
         frm_match     = 4'hF;
      end
   endtask

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   task automatic push_byte(input logic [7:0] b, input logic last);
      bus_item_type it;
      it = '{kind: ITEM_BYTE, data: b, last: last, idx: '0, wdata: '0};
      item_q.push_back(it);
      planned_bytes++;
   endtask

   task automatic push_pause();
      bus_item_type it;
      it = '{kind: ITEM_PAUSE, data: '0, last: 1'b0, idx: '0, wdata: '0};
      item_q.push_back(it);
   endtask

   // register write with junk above the register width
   task automatic push_csr(input logic [CSR_INDEX_BITS-1:0] idx, input int unsigned w,
                           input logic [47:0] val);
      bus_item_type it;
      logic [47:0]  junk;
      junk = {$urandom, $urandom};
      it = '{kind: ITEM_CSR, data: '0, last: 1'b0, idx: idx,
             wdata: ((junk >> w) << w) | val};
      item_q.push_back(it);
      plan_cfg = cfg_write(plan_cfg, idx, it.wdata);
   endtask

   function automatic logic [47:0] field_value(input int unsigned w, input int unsigned style);
      logic [47:0] ones;
      ones = 48'hFFFF_FFFF_FFFF >> (48 - w);
      case (style)
         0: return '0;
         1: return ones;
         default: return {$urandom, $urandom} & ones;
      endcase
   endfunction

   function automatic bit idle_roll(input int unsigned mode);
      case (mode)
         0: return 1'b0;
         1: return $urandom_range(0, 7) == 0;
         default: return $urandom_range(0, 2) == 0;
      endcase
   endfunction

   // frame with headers built from the planned config; spoil bits corrupt one byte of
   // dest mac, source mac, source ip, dest ip, source port, dest port
   task automatic put_frame(input logic [15:0] etype, input logic [3:0] ihl,
                            input logic [7:0] proto, input logic [3:0] doff,
                            input int unsigned len, input logic [5:0] spoil);
      logic [7:0]  hdr [0:255];
      logic [15:0] sp;
      logic [15:0] dp;
      int unsigned i;
      int unsigned l4;
      int unsigned k;
      for (i = 0; i < 256; i++) hdr[i] = 8'($urandom);
      for (i = 0; i < 6; i++) begin
         hdr[i]     = plan_cfg.dest_mac[8 * (5 - i) +: 8];
         hdr[6 + i] = plan_cfg.source_mac[8 * (5 - i) +: 8];
      end
      hdr[12] = etype[15:8];
      hdr[13] = etype[7:0];
      hdr[14] = {4'h4, ihl};
      hdr[23] = proto;
      for (i = 0; i < 4; i++) begin
         hdr[26 + i] = plan_cfg.source_ipv4[8 * (3 - i) +: 8];
         hdr[30 + i] = plan_cfg.dest_ipv4[8 * (3 - i) +: 8];
      end
      l4 = ETH_HDR_BYTES + 4 * ihl;
      sp = (plan_cfg.source_port_want != 0) ? plan_cfg.source_port_want : 16'($urandom);
      dp = (plan_cfg.dest_port_want != 0) ? plan_cfg.dest_port_want : 16'($urandom);
      if (ihl >= IHL_MIN) begin
         hdr[l4]      = sp[15:8];
         hdr[l4 + 1]  = sp[7:0];
         hdr[l4 + 2]  = dp[15:8];
         hdr[l4 + 3]  = dp[7:0];
         hdr[l4 + 12] = {doff, hdr[l4 + 12][3:0]};
      end
      // single-byte mismatches in chosen fields
      for (i = 0; i < 6; i++) begin
         if (spoil[i]) begin
            case (i)
               0: k = $urandom_range(0, 5);
               1: k = $urandom_range(6, 11);
               2: k = $urandom_range(26, 29);
               3: k = $urandom_range(30, 33);
               4: k = l4 + $urandom_range(0, 1);
               default: k = l4 + $urandom_range(2, 3);
            endcase
            hdr[k] = hdr[k] ^ 8'($urandom_range(1, 255));
         end
      end
      for (i = 0; i < len; i++) push_byte((i < 256) ? hdr[i] : 8'($urandom), i == len - 1);
   endtask

   // random frame: mostly well formed, some truncated, some pure noise
   task automatic gen_frame();
      logic [15:0] etype;
      logic [3:0]  ihl;
      logic [3:0]  doff;
      logic [7:0]  proto;
      logic [5:0]  spoil;
      int unsigned pick;
      int unsigned l4;
      int unsigned full;
      int unsigned len;
      int unsigned i;
      if ($urandom_range(0, 15) == 0) begin
         len = $urandom_range(1, 70);
         for (i = 0; i < len; i++) push_byte(8'($urandom), i == len - 1);
      end else begin
         etype = ($urandom_range(0, 15) < 14) ? ETHERTYPE_IPV4 : 16'($urandom);
         pick = $urandom_range(0, 7);
         if (pick < 4) ihl = IHL_MIN;
         else if (pick < 7) ihl = 4'($urandom_range(6, 15));
         else ihl = 4'($urandom_range(0, 4));
         pick = $urandom_range(0, 7);
         if (pick < 3) proto = L4_PROTO_TCP;
         else if (pick < 6) proto = L4_PROTO_UDP;
         else if (pick == 6) proto = plan_cfg.protocol_want;
         else proto = 8'($urandom);
         doff = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 4)) : 4'($urandom_range(5, 15));
         l4 = ETH_HDR_BYTES + 4 * ((ihl < IHL_MIN) ? IHL_MIN : ihl);
         if (proto == L4_PROTO_TCP)
            full = l4 + ((doff < 5) ? TCP_HDR_BYTES : 4 * doff) + $urandom_range(0, 10);
         else if (proto == L4_PROTO_UDP)
            full = l4 + UDP_HDR_BYTES + $urandom_range(0, 10);
         else
            full = l4 + $urandom_range(0, 20);
         len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, full) : full;
         for (i = 0; i < 6; i++) spoil[i] = ($urandom_range(0, 7) == 0);
         put_frame(etype, ihl, proto, doff, len, spoil);
      end
   endtask

   // pause for all verdicts, then a new register setting
   task automatic plan_phase(input int unsigned p);
      int unsigned style;
      int unsigned pick;
      push_pause();
      style = (p == 1) ? 1 : (p == 2) ? 0 : 2;
      if (p < 3 || $urandom_range(0, 1))
         push_csr(CSR_MATCH_ENABLES, 4, field_value(4, style));
      if (p < 3 || $urandom_range(0, 1))
         push_csr(CSR_SOURCE_MAC, 48, field_value(48, (p < 3) ? style : $urandom_range(0, 3)));
      if (p < 3 || $urandom_range(0, 1))
         push_csr(CSR_DEST_MAC, 48, field_value(48, (p < 3) ? style : $urandom_range(0, 3)));
      if (p < 3 || $urandom_range(0, 1))
         push_csr(CSR_SOURCE_IPV4, 32, field_value(32, (p < 3) ? style : $urandom_range(0, 3)));
      if (p < 3 || $urandom_range(0, 1))
         push_csr(CSR_DEST_IPV4, 32, field_value(32, (p < 3) ? style : $urandom_range(0, 3)));
      if (p < 3 || $urandom_range(0, 1))
         push_csr(CSR_SOURCE_PORT, 16, field_value(16, (p < 3) ? style : $urandom_range(0, 1) * 2));
      if (p < 3 || $urandom_range(0, 1))
         push_csr(CSR_DEST_PORT, 16, field_value(16, (p < 3) ? style : $urandom_range(0, 1) * 2));
      // protocol filter: off, tcp, udp or anything
      pick = $urandom_range(0, 3);
      if (p == 1) push_csr(CSR_PROTOCOL, 8, field_value(8, 1));
      else if (p == 0 || p == 2 || pick == 0) push_csr(CSR_PROTOCOL, 8, '0);
      else if (pick == 1) push_csr(CSR_PROTOCOL, 8, 48'(L4_PROTO_TCP));
      else if (pick == 2) push_csr(CSR_PROTOCOL, 8, 48'(L4_PROTO_UDP));
      else push_csr(CSR_PROTOCOL, 8, field_value(8, 2));
   endtask

   // request driver
   always @(negedge clock) begin
      bus_item_type head;
      logic         next_valid;
      logic         next_wen;
      next_valid = req_valid;
      next_wen   = 1'b0;
      if (cycle_count % 256 == 0) send_mode = $urandom_range(0, 2);
      if (!reset && verdict_q.size() == 0 && !req_valid) quiet_cycles++;
      else quiet_cycles = 0;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_valid || beat_taken) begin
         next_valid = 1'b0;
         if (send_left > 0) begin
            send_left--;
         end else if (item_q.size() != 0) begin
            head = item_q[0];
            if (head.kind == ITEM_BYTE) begin
               if (item_q.size() > TAIL_ITEMS && idle_roll(send_mode)) begin
                  send_left = $urandom_range(0, 4);
               end else begin
                  void'(item_q.pop_front());
                  next_valid     = 1'b1;
                  req_byte_value <= head.data;
                  req_frame_end  <= head.last;
               end
            end else if (quiet_cycles >= SETTLE_CYCLES) begin
               // register writes and pauses only once the block has drained
               void'(item_q.pop_front());
               if (head.kind == ITEM_CSR) begin
                  next_wen  = 1'b1;
                  csr_index <= head.idx;
                  csr_wdata <= head.wdata;
               end
            end
         end
      end
      req_valid <= next_valid;
      csr_wen   <= next_wen;
   end

   // verdict stall bursts
   always @(negedge clock) begin
      logic next_stall;
      if (cycle_count % 256 == 128) stall_mode = $urandom_range(0, 2);
      if (reset || item_q.size() <= TAIL_ITEMS) begin
         next_stall = 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         next_stall = 1'b1;
      end else if (idle_roll(stall_mode)) begin
         stall_left = $urandom_range(0, 4);
         next_stall = 1'b1;
      end else begin
         next_stall = 1'b0;
      end
      rsp_stall <= next_stall;
   end

   // monitor: register writes, accepted bytes and verdict beats
   always @(posedge clock) begin
      verdict_type want;
      cycle_count++;
      beat_taken = 1'b0;
      if (!reset) begin
         if (csr_wen) filt_cfg = cfg_write(filt_cfg, csr_index, csr_wdata);
         if (req_valid && !req_stall) begin
            beat_taken = 1'b1;
            filter_byte(req_byte_value, req_frame_end);
         end
         if (rsp_valid && !rsp_stall) begin
            if (verdict_q.size() == 0) begin
               $error("verdict beat with no frame pending");
               fail_count++;
            end else begin
               want = verdict_q.pop_front();
               check_field("accepted", want.accepted, rsp_accepted);
               check_field("drop_reason", want.drop_reason, rsp_drop_reason);
               check_field("ip_protocol", want.ip_protocol, rsp_ip_protocol);
               check_field("src_port", want.src_port, rsp_src_port);
               check_field("dst_port", want.dst_port, rsp_dst_port);
               check_field("payload_offset", want.payload_offset, rsp_payload_offset);
               check_field("frame_length", want.frame_length, rsp_frame_length);
            end
         end
      end
      if (cycle_count > cycle_limit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // stimulus plan, reset and end of run
   initial begin
      int unsigned p;
      int unsigned start_bytes;
      // directed frames under the reset configuration
      put_frame(ETHERTYPE_IPV4, IHL_MIN, L4_PROTO_TCP, 4'd5, 1, '0);
      put_frame(ETHERTYPE_IPV4, IHL_MIN, L4_PROTO_TCP, 4'd5, 13, '0);
      put_frame(16'h86DD, IHL_MIN, L4_PROTO_TCP, 4'd5, 14, '0);
      put_frame(ETHERTYPE_IPV4, IHL_MIN, L4_PROTO_TCP, 4'd5, 14, '0);
      put_frame(ETHERTYPE_IPV4, 4'd4, L4_PROTO_TCP, 4'd5, 33, '0);
      put_frame(ETHERTYPE_IPV4, 4'd4, L4_PROTO_TCP, 4'd5, 34, '0);
      put_frame(ETHERTYPE_IPV4, 4'd0, L4_PROTO_UDP, 4'd5, 60, '0);
      put_frame(ETHERTYPE_IPV4, IHL_MIN, L4_PROTO_TCP, 4'd5, 54, '0);
      put_frame(ETHERTYPE_IPV4, IHL_MIN, L4_PROTO_TCP, 4'd5, 53, '0);
      put_frame(ETHERTYPE_IPV4, IHL_MIN, L4_PROTO_TCP, 4'd5, 40, '0);
      put_frame(ETHERTYPE_IPV4, IHL_MIN, L4_PROTO_UDP, 4'd0, 42, '0);
      put_frame(ETHERTYPE_IPV4, IHL_MIN, L4_PROTO_UDP, 4'd0, 41, '0);
      put_frame(ETHERTYPE_IPV4, IHL_MIN, 8'd1, 4'd0, 60, '0);
      put_frame(ETHERTYPE_IPV4, 4'd15, L4_PROTO_UDP, 4'd0, 86, '0);
      put_frame(ETHERTYPE_IPV4, 4'd15, L4_PROTO_TCP, 4'd15, 136, '0);
      put_frame(ETHERTYPE_IPV4, IHL_MIN, L4_PROTO_TCP, 4'd2, 60, '0);
      put_frame(ETHERTYPE_IPV4, IHL_MIN, L4_PROTO_TCP, 4'd0, 54, '0);
      put_frame(16'h0000, IHL_MIN, L4_PROTO_UDP, 4'd0, 60, '0);
      put_frame(16'hFFFF, IHL_MIN, L4_PROTO_UDP, 4'd0, 60, '0);
      put_frame(16'h0008, IHL_MIN, L4_PROTO_UDP, 4'd0, 60, '0);
      // random phases, each under its own register setting
      for (p = 0; p < PHASES; p++) begin
         plan_phase(p);
         start_bytes = planned_bytes;
         while (planned_bytes - start_bytes < 32) begin
            gen_frame();
            if ($urandom_range(0, 11) == 0) push_pause();
         end
      end
      cycle_limit = 16 * item_q.size() + 20000;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      do @(posedge clock); while (item_q.size() != 0 || req_valid || verdict_q.size() != 0);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
